// ----- hdl/spq_pkg.sv -----
package spq_pkg;

   localparam int QueueDepthDefault = 64;
   localparam int DataW             = 32;
   localparam int OccW              = 7;

   localparam logic CmdEnqueue = 1'b0;
   localparam logic CmdDequeue = 1'b1;

   localparam logic [1:0] StatusDone  = 2'd0;
   localparam logic [1:0] StatusFull  = 2'd1;
   localparam logic [1:0] StatusEmpty = 2'd2;

   typedef struct packed {
      logic signed [DataW-1:0] value;
      logic signed [DataW-1:0] prio;
   } entry_type;

   // status and removed entry of the last finished item
   typedef struct packed {
      logic [1:0] status;
      entry_type  removed;
   } result_type;

   // signed priority a <= b: a stays ahead of a newcomer of priority b
   function automatic logic prio_le(input logic signed [DataW-1:0] a,
                                    input logic signed [DataW-1:0] b);
      return a <= b;
   endfunction

endpackage

// ----- hdl/spq_ifs.sv -----
interface spq_req_if;
   logic                             valid;
   logic                             ready;
   logic                             command;
   logic signed [spq_pkg::DataW-1:0] item_value;
   logic signed [spq_pkg::DataW-1:0] item_priority;

   modport source (output valid, command, item_value, item_priority, input ready);
   modport sink   (input valid, command, item_value, item_priority, output ready);
endinterface

interface spq_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [1:0]                       status;
   logic signed [spq_pkg::DataW-1:0] removed_value;
   logic signed [spq_pkg::DataW-1:0] removed_priority;
   logic                             head_valid;
   logic signed [spq_pkg::DataW-1:0] head_value;
   logic signed [spq_pkg::DataW-1:0] head_priority;
   logic [spq_pkg::OccW-1:0]         occupancy;

   modport source (output valid, status, removed_value, removed_priority, head_valid,
                   head_value, head_priority, occupancy, input ready);
   modport sink   (input valid, status, removed_value, removed_priority, head_valid,
                   head_value, head_priority, occupancy, output ready);
endinterface

// ----- hdl/spq_store.sv -----
module spq_store #(
   parameter int QUEUE_DEPTH = spq_pkg::QueueDepthDefault,
   parameter int AW          = $clog2(QUEUE_DEPTH)
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output spq_pkg::entry_type  rd_data,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  spq_pkg::entry_type  wr_data
);

   spq_pkg::entry_type entries_ff [QUEUE_DEPTH];
   spq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entries_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/spq_ctrl.sv -----
module spq_ctrl #(
   parameter int QUEUE_DEPTH = spq_pkg::QueueDepthDefault,
   parameter int AW          = $clog2(QUEUE_DEPTH),
   parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             command,
   input  logic signed [spq_pkg::DataW-1:0] item_value,
   input  logic signed [spq_pkg::DataW-1:0] item_priority,
   output logic                             done,
   output spq_pkg::result_type              result,
   output spq_pkg::entry_type               head,
   output logic [CW-1:0]                    count,
   output logic                             rd_en,
   output logic [AW-1:0]                    rd_addr,
   input  spq_pkg::entry_type               rd_data,
   output logic                             wr_en,
   output logic [AW-1:0]                    wr_addr,
   output spq_pkg::entry_type               wr_data
);

   localparam logic [1:0] StIdle    = 2'd0;
   localparam logic [1:0] StEnqCmp  = 2'd1;
   localparam logic [1:0] StEnqHead = 2'd2;
   localparam logic [1:0] StDeqMove = 2'd3;

   logic [1:0]          state_ff,  state_in;
   logic [AW-1:0]       idx_ff,    idx_in;
   logic [CW-1:0]       count_ff,  count_in;
   spq_pkg::entry_type  head_ff,   head_in;
   spq_pkg::entry_type  new_ff,    new_in;
   spq_pkg::result_type result_ff, result_in;
   spq_pkg::entry_type  req_entry;

   assign req_entry.value = item_value;
   assign req_entry.prio  = item_priority;

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      count_in  = count_ff;
      head_in   = head_ff;
      new_in    = new_ff;
      result_in = result_ff;
      rd_en     = 1'b0;
      rd_addr   = '0;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = new_ff;
      done      = 1'b0;
      case (state_ff)
         StIdle: begin
            if (start) begin
               new_in           = req_entry;
               result_in.status = spq_pkg::StatusDone;
               result_in.removed = '0;
               if (command == spq_pkg::CmdEnqueue) begin
                  if (count_ff >= CW'(QUEUE_DEPTH)) begin
                     result_in.status = spq_pkg::StatusFull;
                     done             = 1'b1;
                  end else if (count_ff == '0) begin
                     wr_en    = 1'b1;
                     wr_data  = req_entry;
                     head_in  = req_entry;
                     count_in = count_ff + CW'(1);
                     done     = 1'b1;
                  end else begin
                     // walk from the tail toward the head
                     rd_en    = 1'b1;
                     rd_addr  = AW'(count_ff - CW'(1));
                     idx_in   = AW'(count_ff);
                     state_in = StEnqCmp;
                  end
               end else begin
                  if (count_ff == '0) begin
                     result_in.status = spq_pkg::StatusEmpty;
                     done             = 1'b1;
                  end else begin
                     result_in.removed = head_ff;
                     if (count_ff == CW'(1)) begin
                        count_in = '0;
                        done     = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = AW'(1);
                        idx_in   = '0;
                        state_in = StDeqMove;
                     end
                  end
               end
            end
         end
         StEnqCmp: begin
            // rd_data holds entry idx-1
            if (spq_pkg::prio_le(rd_data.prio, new_ff.prio)) begin
               wr_en    = 1'b1;
               wr_addr  = idx_ff;
               count_in = count_ff + CW'(1);
               done     = 1'b1;
               state_in = StIdle;
            end else begin
               wr_en   = 1'b1;
               wr_addr = idx_ff;
               wr_data = rd_data;
               if (idx_ff == AW'(1)) begin
                  idx_in   = '0;
                  state_in = StEnqHead;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = idx_ff - AW'(2);
                  idx_in  = idx_ff - AW'(1);
               end
            end
         end
         StEnqHead: begin
            wr_en    = 1'b1;
            head_in  = new_ff;
            count_in = count_ff + CW'(1);
            done     = 1'b1;
            state_in = StIdle;
         end
         StDeqMove: begin
            // rd_data holds entry idx+1; pull it one place forward
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = rd_data;
            if (idx_ff == '0) begin
               head_in = rd_data;
            end
            if ((CW+1)'(idx_ff) + (CW+1)'(2) < (CW+1)'(count_ff)) begin
               rd_en   = 1'b1;
               rd_addr = AW'((CW+1)'(idx_ff) + (CW+1)'(2));
               idx_in  = idx_ff + AW'(1);
            end else begin
               count_in = count_ff - CW'(1);
               done     = 1'b1;
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      idx_ff    <= idx_in;
      head_ff   <= head_in;
      new_ff    <= new_in;
      result_ff <= result_in;
   end

   assign result = result_ff;
   assign head   = head_ff;
   assign count  = count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("entry count above depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (count_ff == $past(count_ff) || count_ff == $past(count_ff) + CW'(1) ||
                count_ff == $past(count_ff) - CW'(1)))
      else $error("entry count moved by more than one");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == StIdle)
      else $error("item started while sequencer busy");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done |=> state_ff == StIdle)
      else $error("sequencer still busy after finishing");

   a_enq_idx: assert property (@(posedge clock) disable iff (reset)
      state_ff == StEnqCmp |-> idx_ff != '0)
      else $error("insert walk reached the head without a head write");

endmodule

// ----- hdl/sorted_priority_queue.sv -----
// Sorted priority queue: up to QUEUE_DEPTH (value, priority) entries kept in
// ascending signed priority order in a single-port-read, single-port-write RAM.
// req_if carries one item: command 0 enqueues (item_value, item_priority),
// command 1 dequeues the head. Equal priorities leave in arrival order.
// rsp_if returns one item per request: status (done, full, empty), the removed
// entry (zero unless a dequeue succeeded), the head after the step and occupancy.
// An enqueue into a full or empty queue needs no RAM walk; otherwise the stored
// entries whose priority is greater than the new one are read and moved one place
// toward the tail, one RAM read/write per entry, before the new entry is written.
// A dequeue from a queue holding zero or one entry needs no RAM walk; otherwise
// each remaining entry is moved one place toward the head.
// A small sequencer does the work, one RAM entry per cycle: a compare-and-move
// step for enqueue, a move step for dequeue. req ready is low from acceptance
// until the response has been taken, so one item is in flight at a time.
// Reset clears the entry count and the handshakes; the RAM is not cleared.
// A stalled receiver holds the response stable and keeps req ready low.
module sorted_priority_queue #(
   parameter int QUEUE_DEPTH = spq_pkg::QueueDepthDefault
) (
   input logic       clock,
   input logic       reset,
   spq_req_if.sink   req_if,
   spq_rsp_if.source rsp_if
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic                busy_ff,      busy_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                start;
   logic                done;
   spq_pkg::result_type result;
   spq_pkg::entry_type  head;
   logic [CW-1:0]       count;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   spq_pkg::entry_type  rd_data;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   spq_pkg::entry_type  wr_data;
   logic                head_valid;

   // take a new item only once the previous response has left
   assign req_if.ready = !busy_ff;
   assign start        = req_if.valid && !busy_ff;

   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      if (start) begin
         busy_in = 1'b1;
      end
      if (done) begin
         rsp_valid_in = 1'b1;
      end
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
         busy_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   spq_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .AW          (AW),
      .CW          (CW)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .command       (req_if.command),
      .item_value    (req_if.item_value),
      .item_priority (req_if.item_priority),
      .done          (done),
      .result        (result),
      .head          (head),
      .count         (count),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data)
   );

   spq_store #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .AW          (AW)
   ) u_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // head and count are final once the sequencer is done; zero the head when empty
   assign head_valid              = (count != '0);
   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.status           = result.status;
   assign rsp_if.removed_value    = result.removed.value;
   assign rsp_if.removed_priority = result.removed.prio;
   assign rsp_if.head_valid       = head_valid;
   assign rsp_if.head_value       = head_valid ? head.value : '0;
   assign rsp_if.head_priority    = head_valid ? head.prio : '0;
   assign rsp_if.occupancy        = spq_pkg::OccW'(count);

endmodule
